// ===== rtl/wsfd_pkg.sv =====
// Package with the item types and framing constants of the WebSocket frame decoder.
`default_nettype none

package wsfd_pkg;

  localparam int unsigned LenW = 63;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic            final_flag;
    logic [3:0]      opcode;
    logic            masked_flag;
    logic [LenW-1:0] payload_length;
    logic [7:0]      data_byte;
    logic            last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic require_mask;
  } cfg_item_t;

  // Result of one parser step: whether the byte produced a result, and that result.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/wsfd_chan_if.sv =====
// Valid/ready channel interface carrying one payload item per transfer.
`default_nettype none

interface wsfd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/websocket_frame_decoder_core.sv =====
// Top level of the WebSocket frame decoder: channels, configuration and result register.
// Results are registered: each appears in the cycle after its byte's transfer.
// Throughput: one frame byte per cycle, sustained, as long as results are taken.
// The output register is a single stage; a stalled result holds the input off only
// while it is not being taken, so a byte is accepted in the same cycle a result leaves.
// Reset (rst_ni low, asynchronous): parser waits for a first header byte, require_mask = 1.
`default_nettype none

module websocket_frame_decoder_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wsfd_chan_if.sink   frame_i,
  wsfd_chan_if.source result_o,
  wsfd_chan_if.sink   cfg_i
);
  import wsfd_pkg::*;

  // Configuration: the register may be written in any cycle; it is sampled by
  // the parser only when a header completes, so a frame in progress keeps its rule.
  logic require_mask_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      require_mask_q <= 1'b1;
    end else if (cfg_i.valid) begin
      require_mask_q <= cfg_i.data.require_mask;
    end
  end

  // A byte is taken whenever the output register is empty or is emptied in this cycle.
  logic      frame_xfer;
  logic      out_valid_q;
  out_item_t out_item_q;
  res_t      step_res;

  assign frame_i.ready = !out_valid_q || result_o.ready;
  assign frame_xfer    = frame_i.valid && frame_i.ready;

  // The parser holds all frame state and works out the result of one byte
  // combinationally from the current state.
  wsfd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (frame_xfer),
    .frame_byte_i   (frame_i.data.frame_byte),
    .require_mask_i (require_mask_q),
    .res_o          (step_res)
  );

  // Result register. It refills on the same edge a pending result is taken,
  // and empties when taken with no new result behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_i.ready) begin
      out_valid_q <= frame_xfer && step_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_xfer && step_res.valid) begin
      out_item_q <= step_res.item;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

  // Input is held off only while a result is pending and not being taken.
  a_ready_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_i.ready |-> (out_valid_q && !result_o.ready))
    else $error("input stalled without a blocked result");

  // A transfer that yields a result leaves a valid result in the register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_xfer && step_res.valid) |=> out_valid_q)
    else $error("result of a transferred byte was dropped");

  // A result that was taken with no new byte yielding one empties the register.
  a_result_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_o.ready && !(frame_xfer && step_res.valid)) |=> !out_valid_q)
    else $error("taken result was repeated");

endmodule

`default_nettype wire

// ===== rtl/wsfd_parser.sv =====
// Frame header parser and payload unmasking state machine, one byte per step.
`default_nettype none

module wsfd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    frame_byte_i,
  input  wire logic          require_mask_i,
  output wsfd_pkg::res_t     res_o
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            fin_q, fin_d;
  logic [3:0]      op_q, op_d;
  logic            mask_q, mask_d;
  logic [LenW-1:0] len_q, len_d;
  logic [3:0]      left_q, left_d;
  logic [31:0]     key_q, key_d;
  logic [LenW-1:0] remain_q, remain_d;
  logic [1:0]      idx_q, idx_d;
  logic            deliver_q, deliver_d;

  logic            len_done;
  logic            hdr_done;
  logic            has_payload;
  logic [6:0]      len7;
  logic [7:0]      key_byte;
  logic            pay_last;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    op_d      = op_q;
    mask_d    = mask_q;
    len_d     = len_q;
    left_d    = left_q;
    key_d     = key_q;
    remain_d  = remain_q;
    idx_d     = idx_q;
    deliver_d = deliver_q;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    res_o     = '0;
    len7      = frame_byte_i[6:0];
    key_byte  = key_q[{~idx_q, 3'b000} +: 8];
    pay_last  = (remain_q == LenW'(1));

    case (phase_q)
      PH_HDR1: begin
        mask_d = frame_byte_i[7];
        key_d  = '0;
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          left_d  = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          len_d   = '0;
          phase_d = PH_EXTLEN;
        end else begin
          len_d    = LenW'(len7);
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        // The top bit of the 64-bit form falls off the 63-bit accumulator.
        len_d  = {len_q[LenW-9:0], frame_byte_i};
        left_d = left_q - 4'd1;
        if (left_d == 4'd0) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_d  = {key_q[23:0], frame_byte_i};
        left_d = left_q - 4'd1;
        if (left_d == 4'd0) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        idx_d    = idx_q + 2'd1;
        remain_d = remain_q - LenW'(1);
        if (pay_last) begin
          phase_d = PH_HDR0;
        end
        if (deliver_q) begin
          res_o.valid              = 1'b1;
          res_o.item.kind          = KIND_PAYLOAD;
          res_o.item.data_byte     = frame_byte_i ^ key_byte;
          res_o.item.last_of_frame = pay_last;
        end
      end
      default: begin
        fin_d   = frame_byte_i[7];
        op_d    = frame_byte_i[3:0];
        phase_d = PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (mask_d) begin
        left_d  = KEY_BYTES;
        phase_d = PH_KEY;
      end else begin
        key_d    = '0;
        hdr_done = 1'b1;
      end
    end

    has_payload = (len_d != '0);
    if (hdr_done) begin
      deliver_d                = (op_d == OP_TEXT) && (mask_d || !require_mask_i);
      remain_d                 = len_d;
      idx_d                    = '0;
      phase_d                  = has_payload ? PH_PAYLOAD : PH_HDR0;
      res_o.valid              = 1'b1;
      res_o.item.kind          = KIND_HEADER;
      res_o.item.data_byte     = '0;
      res_o.item.last_of_frame = !(deliver_d && has_payload);
    end

    res_o.item.final_flag     = fin_d;
    res_o.item.opcode         = op_d;
    res_o.item.masked_flag    = mask_d;
    res_o.item.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      fin_q     <= 1'b0;
      op_q      <= '0;
      mask_q    <= 1'b0;
      len_q     <= '0;
      left_q    <= '0;
      key_q     <= '0;
      remain_q  <= '0;
      idx_q     <= '0;
      deliver_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      op_q      <= op_d;
      mask_q    <= mask_d;
      len_q     <= len_d;
      left_q    <= left_d;
      key_q     <= key_d;
      remain_q  <= remain_d;
      idx_q     <= idx_d;
      deliver_q <= deliver_d;
    end
  end

  // A payload phase always has at least one byte still to come.
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> remain_q != '0)
    else $error("payload phase with no bytes remaining");

  // Extended length and key phases always count down from a nonzero value.
  a_hdr_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXTLEN || phase_q == PH_KEY) |-> left_q != 4'd0)
    else $error("header byte counter empty in a counting phase");

  // Payload results appear only for frames latched as delivered.
  a_payload_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid && res_o.item.kind == KIND_PAYLOAD) |-> deliver_q)
    else $error("payload result for a frame that is not delivered");

endmodule

`default_nettype wire

// ===== sim/wsfd_frame_tracker.sv =====
// Watches the decoder's channels, parses the byte stream alongside it and compares the results.
`timescale 1ns / 100ps

module wsfd_frame_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  input  logic                frame_ready_i,
  input  wsfd_pkg::in_item_t  frame_data_i,
  input  logic                result_valid_i,
  input  logic                result_ready_i,
  input  wsfd_pkg::out_item_t result_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  wsfd_pkg::cfg_item_t cfg_data_i,
  output int unsigned         mismatch_cnt_o,
  output int unsigned         pending_o
);
  import wsfd_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXT_LEN = 3'd2,
    PH_KEY     = 3'd3,
    PH_DATA    = 3'd4
  } parse_phase_e;

  parse_phase_e phase_q;
  logic         mask_rule_q;
  logic         fin_q;
  logic         mask_q;
  logic         deliver_q;
  logic [3:0]   opcode_q;
  logic [3:0]   left_q;
  logic [63:0]  len_q;
  logic [63:0]  count_q;
  logic [31:0]  key_q;

  // Decoded results that the block still owes, oldest first.
  out_item_t    decoded_q[$];
  int unsigned  n_mismatch;

  function automatic out_item_t frame_result(logic kind, logic [7:0] data, logic last);
    out_item_t r;
    r.kind           = kind;
    r.final_flag     = fin_q;
    r.opcode         = opcode_q;
    r.masked_flag    = mask_q;
    r.payload_length = len_q[LenW-1:0];
    r.data_byte      = data;
    r.last_of_frame  = last;
    return r;
  endfunction

  // The header is complete: latch the delivery decision and report the header.
  task automatic close_header(output bit produced, output out_item_t res);
    deliver_q = (opcode_q == OP_TEXT) && (mask_q || !mask_rule_q);
    count_q   = '0;
    phase_q   = (len_q != 0) ? PH_DATA : PH_FIRST;
    produced  = 1'b1;
    res       = frame_result(KIND_HEADER, 8'h00, !(deliver_q && len_q != 0));
  endtask

  // The length is known: read a key next, or finish the header of an unmasked frame.
  task automatic close_length(output bit produced, output out_item_t res);
    if (mask_q) begin
      left_q   = KEY_BYTES;
      phase_q  = PH_KEY;
      produced = 1'b0;
      res      = '0;
    end else begin
      key_q = '0;
      close_header(produced, res);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, output bit produced, output out_item_t res);
    logic [1:0] idx;
    logic [7:0] key_b;
    produced = 1'b0;
    res      = '0;
    case (phase_q)
      PH_SECOND: begin
        mask_q = b[7];
        key_q  = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          left_q  = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          len_q   = '0;
          phase_q = PH_EXT_LEN;
        end else begin
          len_q = {57'd0, b[6:0]};
          close_length(produced, res);
        end
      end
      PH_EXT_LEN: begin
        len_q  = {len_q[55:0], b};
        left_q = left_q - 4'd1;
        if (left_q == 0) begin
          len_q[63] = 1'b0;
          close_length(produced, res);
        end
      end
      PH_KEY: begin
        key_q  = {key_q[23:0], b};
        left_q = left_q - 4'd1;
        if (left_q == 0) begin
          close_header(produced, res);
        end
      end
      PH_DATA: begin
        idx     = count_q[1:0];
        key_b   = key_q[8 * (3 - int'(idx)) +: 8];
        count_q = count_q + 64'd1;
        if (count_q >= len_q) begin
          phase_q = PH_FIRST;
        end
        if (deliver_q) begin
          produced = 1'b1;
          res      = frame_result(KIND_PAYLOAD, b ^ key_b, phase_q == PH_FIRST);
        end
      end
      default: begin
        fin_q    = b[7];
        opcode_q = b[3:0];
        phase_q  = PH_SECOND;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    bit        produced;
    out_item_t res;
    out_item_t want;
    string     bad;
    if (!rst_ni) begin
      phase_q     = PH_FIRST;
      mask_rule_q = 1'b1;
      fin_q       = 1'b0;
      mask_q      = 1'b0;
      deliver_q   = 1'b0;
      opcode_q    = '0;
      left_q      = '0;
      len_q       = '0;
      count_q     = '0;
      key_q       = '0;
      n_mismatch  = 0;
      decoded_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      // Results leaving now belong to bytes taken at earlier edges, so compare first.
      if (result_valid_i && result_ready_i) begin
        if (decoded_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= ReportLimit) begin
            $display("%0t: result with no byte to account for it: %p", $time, result_data_i);
          end
        end else begin
          want = decoded_q.pop_front();
          bad  = "";
          if (result_data_i.kind !== want.kind) bad = {bad, " kind"};
          if (result_data_i.final_flag !== want.final_flag) bad = {bad, " final_flag"};
          if (result_data_i.opcode !== want.opcode) bad = {bad, " opcode"};
          if (result_data_i.masked_flag !== want.masked_flag) bad = {bad, " masked_flag"};
          if (result_data_i.payload_length !== want.payload_length) bad = {bad, " length"};
          if (result_data_i.data_byte !== want.data_byte) bad = {bad, " data_byte"};
          if (result_data_i.last_of_frame !== want.last_of_frame) bad = {bad, " last"};
          if (bad != "") begin
            n_mismatch++;
            if (n_mismatch <= ReportLimit) begin
              $display("%0t: mismatch in%s", $time, bad);
              $display("  expected %p", want);
              $display("  actual   %p", result_data_i);
            end
          end
        end
      end
      if (frame_valid_i && frame_ready_i) begin
        decode_byte(frame_data_i.frame_byte, produced, res);
        if (produced) begin
          decoded_q.push_back(res);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        mask_rule_q = cfg_data_i.require_mask;
      end
      mismatch_cnt_o <= n_mismatch;
      pending_o      <= decoded_q.size();
    end
  end

endmodule

// ===== sim/websocket_frame_decoder_core_tb.sv =====
// Top of the frame decoder testbench: clock, reset, frame stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module websocket_frame_decoder_core_tb;
  import wsfd_pkg::*;

  // The block answers in the cycle after a transfer; the settle wait then covers any byte still
  // in flight that produces no result.
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DirectedItems = 40;
  localparam int unsigned SegmentItems  = 160;
  localparam int unsigned Segments      = 4;
  // Frames in the eight-byte length form longer than this only get this many payload
  // bytes; only the last frame of the run is that long, so nothing after it is misparsed.
  localparam longint unsigned PayloadCap = 48;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned IdlePct       = 36;
  localparam int          TimeoutNs     = 2_000_000;

  typedef enum int {
    LEN_SHORT,
    LEN_16,
    LEN_64
  } len_form_e;

  logic clk = 1'b0;
  logic rst_n;

  wsfd_chan_if #(.payload_t(in_item_t))  frame_if ();
  wsfd_chan_if #(.payload_t(out_item_t)) result_if ();
  wsfd_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  // Knobs set by the stimulus for the sender and the receiver.
  int unsigned src_gap_pct  = IdlePct;
  int unsigned sink_gap_pct = IdlePct;
  int unsigned hold_off_req = 0;

  int unsigned item_count = 0;

  websocket_frame_decoder_core i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .frame_i  (frame_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  wsfd_frame_tracker i_tracker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .frame_valid_i  (frame_if.valid),
    .frame_ready_i  (frame_if.ready),
    .frame_data_i   (frame_if.data),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .result_data_i  (result_if.data),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_ready_i    (cfg_if.ready),
    .cfg_data_i     (cfg_if.data),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one byte, with random idle cycles ahead of it, and returns at the edge of its
  // transfer. Valid stays high on return so that back-to-back bytes never drop it.
  task automatic send_byte(input logic [7:0] b, input bit counts);
    while ($urandom_range(99) < src_gap_pct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid           <= 1'b1;
    frame_if.data.frame_byte <= b;
    @(posedge clk);
    while (!frame_if.ready) begin
      @(posedge clk);
    end
    if (counts) begin
      item_count++;
    end
  endtask

  // Sends one complete frame: both header bytes, the extended length in the chosen form,
  // a random key when masked, then random payload.
  task automatic send_frame(input logic [7:0] head, input bit masked, input len_form_e form,
                            input logic [62:0] plen, input bit top_bit);
    logic [31:0]     key;
    logic [63:0]     ext;
    longint unsigned n_pay;
    key = $urandom();
    send_byte(head, 1'b1);
    case (form)
      LEN_SHORT: begin
        send_byte({masked, plen[6:0]}, 1'b1);
      end
      LEN_16: begin
        send_byte({masked, LEN_EXT16}, 1'b1);
        send_byte(plen[15:8], 1'b1);
        send_byte(plen[7:0], 1'b1);
      end
      default: begin
        send_byte({masked, LEN_EXT64}, 1'b1);
        ext = {top_bit, plen};
        for (int i = 7; i >= 0; i--) begin
          send_byte(ext[8 * i +: 8], 1'b1);
        end
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) begin
        send_byte(key[8 * i +: 8], 1'b1);
      end
    end
    n_pay = (form == LEN_64 && longint'(plen) > PayloadCap) ? PayloadCap : longint'(plen);
    for (longint unsigned i = 0; i < n_pay; i++) begin
      send_byte(8'($urandom()), 1'b1);
    end
  endtask

  // Mostly text frames, so that payload gets unmasked and delivered; the rest are control,
  // binary, continuation and reserved opcodes, unmasked text that may be refused, random
  // reserved bits and extended lengths that a shorter form would have fit.
  task automatic send_random_frame();
    logic [7:0]  head;
    logic [62:0] plen;
    bit          masked;
    len_form_e   form;
    int unsigned pick;
    head = 8'($urandom());
    if ($urandom_range(99) < 55) begin
      head[3:0] = OP_TEXT;
    end
    masked = ($urandom_range(99) < 70);
    pick   = $urandom_range(99);
    if (pick < 88) begin
      form = LEN_SHORT;
      if (pick < 50) begin
        plen = 63'($urandom_range(6));
      end else if (pick < 80) begin
        plen = 63'($urandom_range(20, 7));
      end else begin
        plen = 63'($urandom_range(125, 21));
      end
    end else if (pick < 96) begin
      form = LEN_16;
      plen = $urandom_range(1) ? 63'($urandom_range(40)) : 63'($urandom_range(300, 126));
    end else begin
      form = LEN_64;
      plen = 63'($urandom_range(24));
    end
    send_frame(head, masked, form, plen, 1'($urandom()));
  endtask

  // Stops offering bytes and waits until every predicted result has been taken, then lets
  // any byte that produces no result work its way through.
  task automatic drain();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mask_rule(input bit rule);
    cfg_if.valid             <= 1'b1;
    cfg_if.data.require_mask <= rule;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Receiver: random stalls, and on request one long hold-off during which the sender
  // keeps offering bytes, so the result register fills and the input backs up.
  initial begin : result_sink
    int unsigned seen;
    seen = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != seen) begin
        seen = hold_off_req;
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      result_if.ready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  initial begin : stimulus
    logic [62:0] huge_len;
    rst_n                    <= 1'b0;
    frame_if.valid           <= 1'b0;
    frame_if.data            <= '0;
    cfg_if.valid             <= 1'b0;
    cfg_if.data              <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset value of require_mask. A masked text frame is
    // delivered. An unmasked empty text frame ends with its header. An unmasked text frame
    // is refused, so its payload goes by silently. A binary frame with reserved bits set
    // uses the eight-byte length with its top bit set, which must be ignored. A masked
    // ping states a length of two in the sixteen-bit form.
    send_frame(8'h81, 1'b1, LEN_SHORT, 63'd3, 1'b0);
    send_frame(8'h01, 1'b0, LEN_SHORT, 63'd0, 1'b0);
    send_frame(8'h01, 1'b0, LEN_SHORT, 63'd1, 1'b0);
    send_frame(8'hF2, 1'b0, LEN_64, 63'd1, 1'b1);
    send_frame(8'h89, 1'b1, LEN_16, 63'd2, 1'b0);

    // Random segments alternate the register between its two values. The second one runs
    // with no idling on either side, and the third starts the long receiver hold-off.
    for (int seg = 0; seg < Segments; seg++) begin
      drain();
      write_mask_rule(seg % 2 == 1);
      src_gap_pct   = (seg == 1) ? 0 : IdlePct;
      sink_gap_pct <= (seg == 1) ? 0 : IdlePct;
      if (seg == 2) begin
        hold_off_req <= hold_off_req + 1;
      end
      if (seg == 0) begin
        // With the mask no longer required, an unmasked non-final text frame is delivered
        // with a key of zero.
        send_frame(8'h01, 1'b0, LEN_SHORT, 63'd2, 1'b0);
      end
      while (item_count < DirectedItems + (seg + 1) * SegmentItems) begin
        send_random_frame();
      end
    end

    // A last masked text frame with a huge random length drives the high length bits;
    // only the start of its payload is sent.
    huge_len     = {31'($urandom()), 32'($urandom())};
    huge_len[40] = 1'b1;
    send_frame(8'h81, 1'b1, LEN_64, huge_len, 1'($urandom()));
    drain();

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

endmodule
